FILE: hdl/btbe_pkg.sv
// ----------------------------------------------------------------------------
// btbe_pkg
// Types, constants and helpers shared by the buddy tree bitmap engine.
// ----------------------------------------------------------------------------
`default_nettype none

package btbe_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int LVL_W      = 3;
  localparam int IDX_W      = 8;
  localparam int NODE_W     = 9;
  localparam int MODE_W     = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE        = 3'd0,
    MODE_READ         = 3'd1,
    MODE_FILL_SUBTREE = 3'd2,
    MODE_FILL_PATH    = 3'd3,
    MODE_MERGE        = 3'd4,
    MODE_TEST_CLEAR   = 3'd5
  } btbe_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MCHK,
    ST_MCLR,
    ST_FIN
  } btbe_state_e;

  typedef struct packed {
    logic              we;
    logic              val;
    logic [LVL_W-1:0]  lvl;
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
  } btbe_cmd_t;

  typedef struct packed {
    logic any_set;
  } btbe_rsp_t;

  // tree level of a heap-ordered node below 255
  function automatic logic [LVL_W-1:0] level_of(logic [IDX_W-1:0] n);
    logic [IDX_W:0]   m;
    logic [LVL_W-1:0] lvl;
    m   = {1'b0, n} + {{IDX_W{1'b0}}, 1'b1};
    lvl = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (m[i]) begin
        lvl = LVL_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/btbe_level_store.sv
// ----------------------------------------------------------------------------
// btbe_level_store
// Node bits kept as one word per tree level, with a range mask unit that
// writes or tests a span of nodes of one level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btbe_level_store #(
  parameter int LEVELS = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire btbe_pkg::btbe_cmd_t      cmd_i,
  input  wire [btbe_pkg::NODE_W-1:0]    lim_i,
  output btbe_pkg::btbe_rsp_t           rsp_o
);
  import btbe_pkg::*;

  localparam int W     = 1 << (LEVELS - 1);
  localparam int SEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [W-1:0]      word_q [LEVELS];
  logic [W-1:0]      mask;
  logic [W-1:0]      rd_word;
  logic [NODE_W-1:0] base;

  always_comb begin
    logic [NODE_W-1:0] nd;
    base = ({{(NODE_W-1){1'b0}}, 1'b1} << cmd_i.lvl) - {{(NODE_W-1){1'b0}}, 1'b1};
    for (int k = 0; k < W; k++) begin
      nd      = base + NODE_W'(k);
      mask[k] = (nd >= cmd_i.lo) && (nd <= cmd_i.hi) && (nd < lim_i);
    end
  end

  always_comb begin
    if ({1'b0, cmd_i.lvl} < (LVL_W + 1)'(LEVELS)) begin
      rd_word = word_q[cmd_i.lvl[SEL_W-1:0]];
    end else begin
      rd_word = '0;
    end
  end

  assign rsp_o.any_set = |(rd_word & mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        word_q[i] <= '0;
      end
    end else if (cmd_i.we) begin
      for (int i = 0; i < LEVELS; i++) begin
        if (cmd_i.lvl == LVL_W'(i)) begin
          for (int k = 0; k < W; k++) begin
            if (mask[k]) begin
              word_q[i][k] <= cmd_i.val;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/buddy_tree_bitmap_engine.sv
// ----------------------------------------------------------------------------
// buddy_tree_bitmap_engine
// Buddy allocator tree bitmap: one bit per heap-ordered node with write,
// read, subtree fill, ancestor fill, buddy merge and subtree clear test.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_axis_tready_o is low while it runs.
// The sequencer walks the tree one level per cycle through the shared level
// mask unit (a merge uses a check and a clear state per level): write and
// read touch the node alone, a subtree clear test the populated levels
// below the node, a subtree fill those and the node's own level, an
// ancestor fill the node and its path to the root, a merge each level it
// climbs. An out-of-range index or an unused mode goes straight to the
// final state. A finished result waits in the output register while the
// next command is accepted; while that register is still full the sequencer
// holds in its final state. The bit store is cleared at once by reset.
`default_nettype none

module buddy_tree_bitmap_engine #(
  parameter int TREE_LEVELS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire  [7:0] cfg_data_i,    // active_nodes
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire [15:0] s_axis_tdata_i, // [7:0] node_index, [8] new_value, zero pad
  input  wire  [2:0] s_axis_tuser_i, // [2:0] mode
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o, // [0] bit_result, zero pad
  output logic       m_axis_tuser_o  // [0] status
);
  import btbe_pkg::*;

  localparam int LEVELS  = (TREE_LEVELS < MAX_LEVELS) ? TREE_LEVELS : MAX_LEVELS;
  localparam int CAP_SAT = (TREE_LEVELS < MAX_LEVELS) ? ((1 << TREE_LEVELS) - 1) : 255;
  localparam logic [NODE_W-1:0] CAP_N = NODE_W'(CAP_SAT);
  localparam logic [NODE_W-1:0] ONE_N = {{(NODE_W-1){1'b0}}, 1'b1};
  localparam logic [LVL_W-1:0]  ONE_L = {{(LVL_W-1){1'b0}}, 1'b1};

  btbe_state_e       state_q, state_d;
  btbe_mode_e        mode_q, mode_d;
  logic              val_q, val_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [NODE_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic              clr_q, clr_d;
  logic              res_bit_q, res_bit_d, res_st_q, res_st_d;
  logic              out_vld_q, out_vld_d, out_bit_q, out_bit_d, out_st_q, out_st_d;
  logic [IDX_W-1:0]  active_q;

  logic [NODE_W-1:0] lim;
  logic [NODE_W-1:0] idx;
  logic [NODE_W-1:0] buddy;
  logic [NODE_W-1:0] parent;
  logic              s_acc, idx_bad, lo_oor, lo_zero, out_free;
  btbe_cmd_t         cmd;
  btbe_rsp_t         rsp;

  assign lim      = ({1'b0, active_q} < CAP_N) ? {1'b0, active_q} : CAP_N;
  assign idx      = {1'b0, s_axis_tdata_i[7:0]};
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_bad  = idx >= lim;
  assign lo_oor   = lo_q >= lim;
  assign lo_zero  = lo_q == '0;
  assign buddy    = lo_q[0] ? (lo_q + ONE_N) : (lo_q - ONE_N);
  assign parent   = (lo_q - ONE_N) >> 1;
  assign out_free = !out_vld_q || m_axis_tready_i;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_bit_q};
  assign m_axis_tuser_o  = out_st_q;

  btbe_level_store #(
    .LEVELS(LEVELS)
  ) u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .lim_i (lim),
    .rsp_o (rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (idx_bad) begin
            state_d = ST_FIN;
          end else begin
            unique case (s_axis_tuser_i)
              MODE_WRITE, MODE_READ, MODE_FILL_SUBTREE,
              MODE_FILL_PATH, MODE_TEST_CLEAR: state_d = ST_WALK;
              MODE_MERGE:                      state_d = ST_MCHK;
              default:                         state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_WALK: begin
        unique case (mode_q)
          MODE_FILL_SUBTREE, MODE_TEST_CLEAR: begin
            if (lo_oor) begin
              state_d = ST_FIN;
            end
          end
          MODE_FILL_PATH: begin
            if (lo_zero) begin
              state_d = ST_FIN;
            end
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_MCHK: begin
        if (lo_zero || rsp.any_set) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MCLR;
        end
      end
      ST_MCLR: state_d = ST_MCHK;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    mode_d    = mode_q;
    val_d     = val_q;
    lvl_d     = lvl_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    clr_d     = clr_q;
    res_bit_d = res_bit_q;
    res_st_d  = res_st_q;
    out_bit_d = out_bit_q;
    out_st_d  = out_st_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    cmd.we    = 1'b0;
    cmd.val   = val_q;
    cmd.lvl   = lvl_q;
    cmd.lo    = lo_q;
    cmd.hi    = hi_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          mode_d    = btbe_mode_e'(s_axis_tuser_i);
          val_d     = s_axis_tdata_i[8];
          lvl_d     = level_of(s_axis_tdata_i[7:0]);
          lo_d      = idx;
          hi_d      = idx;
          clr_d     = 1'b1;
          res_bit_d = 1'b0;
          res_st_d  = idx_bad;
          if (s_axis_tuser_i == MODE_TEST_CLEAR) begin
            lo_d  = {s_axis_tdata_i[7:0], 1'b1};
            hi_d  = {s_axis_tdata_i[7:0], 1'b0} + (ONE_N << 1);
            lvl_d = level_of(s_axis_tdata_i[7:0]) + ONE_L;
          end
        end
      end
      ST_WALK: begin
        cmd.we = ((mode_q == MODE_WRITE) || (mode_q == MODE_FILL_SUBTREE) ||
                  (mode_q == MODE_FILL_PATH)) && !lo_oor;
        unique case (mode_q)
          MODE_READ: res_bit_d = rsp.any_set;
          MODE_FILL_SUBTREE, MODE_TEST_CLEAR: begin
            if (lo_oor) begin
              res_bit_d = (mode_q == MODE_TEST_CLEAR) && clr_q;
            end else begin
              if (rsp.any_set) begin
                clr_d = 1'b0;
              end
              lo_d  = {lo_q[NODE_W-2:0], 1'b1};
              hi_d  = {hi_q[NODE_W-2:0], 1'b0} + (ONE_N << 1);
              lvl_d = lvl_q + ONE_L;
            end
          end
          MODE_FILL_PATH: begin
            if (!lo_zero) begin
              lo_d  = parent;
              hi_d  = parent;
              lvl_d = lvl_q - ONE_L;
            end
          end
          default: ;
        endcase
      end
      ST_MCHK: begin
        cmd.lo = buddy;
        cmd.hi = buddy;
        if (!lo_zero && !rsp.any_set) begin
          lo_d  = parent;
          hi_d  = parent;
          lvl_d = lvl_q - ONE_L;
        end
      end
      ST_MCLR: begin
        cmd.we  = 1'b1;
        cmd.val = 1'b0;
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_bit_d = res_bit_q;
          out_st_d  = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      active_q  <= 8'd255;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    val_q     <= val_d;
    lvl_q     <= lvl_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    clr_q     <= clr_d;
    res_bit_q <= res_bit_d;
    res_st_q  <= res_st_d;
    out_bit_q <= out_bit_d;
    out_st_q  <= out_st_d;
  end

  // after an accepted command the input side is closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // the store is only written inside the valid node range
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.we |-> (cmd.lo < lim) && (cmd.lo <= cmd.hi))
    else $error("store write outside valid range");

  // an out-of-range result never carries a set bit
  a_bad_index_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tdata_o[0])
    else $error("bit set on out-of-range result");

endmodule

`default_nettype wire
